>>> hdl/dmks_pkg.sv
// Shared types and constants for the DC motor kick-start speed controller.
package dmks_pkg;

  // Motor phase codes.
  typedef enum logic [2:0] {
    PH_STOPPED  = 3'd0,
    PH_STARTING = 3'd1,
    PH_MOVING   = 3'd2,
    PH_BEFORE   = 3'd3,
    PH_PEAK     = 3'd4,
    PH_DROP     = 3'd5
  } phase_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    CT_IDLE   = 3'd0,
    CT_DECIDE = 3'd1,
    CT_RANGE  = 3'd2,
    CT_MUL    = 3'd3,
    CT_APPLY  = 3'd4,
    CT_DONE   = 3'd5
  } ctrl_state_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KICK_LEVEL  = 2'd0;
  localparam logic [1:0] CFG_KICK_TICKS  = 2'd1;
  localparam logic [1:0] CFG_START_LEVEL = 2'd2;
  localparam logic [1:0] CFG_SWITCH_TRIM = 2'd3;

  localparam logic [7:0]  DUTY_OFF        = 8'd255;
  localparam logic [7:0]  TRIM_RESET      = 8'd128;
  localparam logic [15:0] TICK_MAX        = 16'hFFFF;
  localparam logic [15:0] DROP_MAX_WINDOWS = 16'd10;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_in;
    logic decide;
    logic calc_range;
    logic calc_mul;
    logic apply;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic need_drive;
  } ctrl_sts_t;

endpackage

>>> hdl/dmks_ctrl.sv
// Sequencer for one control tick: decide, optional drive mapping, result hand-off.
module dmks_ctrl
  import dmks_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CT_IDLE:   if (in_valid) state_nxt = CT_DECIDE;
      CT_DECIDE: state_nxt = sts.need_drive ? CT_RANGE : CT_DONE;
      CT_RANGE:  state_nxt = CT_MUL;
      CT_MUL:    state_nxt = CT_APPLY;
      CT_APPLY:  state_nxt = CT_DONE;
      CT_DONE:   if (!out_valid_r || out_ready) state_nxt = CT_IDLE;
      default:   state_nxt = CT_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd            = '0;
    cmd.load_in    = (state_r == CT_IDLE) && in_valid;
    cmd.decide     = (state_r == CT_DECIDE);
    cmd.calc_range = (state_r == CT_RANGE);
    cmd.calc_mul   = (state_r == CT_MUL);
    cmd.apply      = (state_r == CT_APPLY);
    cmd.load_out   = (state_r == CT_DONE) && (!out_valid_r || out_ready);
  end

  // The result register stays valid until the downstream side takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CT_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == CT_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hdl/dmks_datapath.sv
// Datapath: configuration, motor phase state, window sums and duty mapping.
module dmks_datapath
  import dmks_pkg::*;
#(
  parameter int WINDOW_SAMPLES = 10,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output ctrl_sts_t   sts,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [7:0]  in_speed,
  input  logic        in_direction,
  input  logic        in_switching_mode,
  input  logic        in_stop_request,
  input  logic [11:0] in_motor_sample,
  output logic [7:0]  out_duty_pin_a,
  output logic [7:0]  out_duty_pin_b,
  output logic        out_duty_update,
  output logic        out_ready_to_accelerate
);

  localparam logic [3:0]  WIN_COUNT   = 4'(WINDOW_SAMPLES);
  localparam logic [11:0] SAMPLE_MASK = 12'((1 << SAMPLE_BITS) - 1);

  // Configuration registers.
  logic [7:0] kick_level_r, kick_ticks_r, start_level_r, switch_trim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kick_level_r  <= '0;
      kick_ticks_r  <= '0;
      start_level_r <= '0;
      switch_trim_r <= TRIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KICK_LEVEL:  kick_level_r  <= cfg_data;
        CFG_KICK_TICKS:  kick_ticks_r  <= cfg_data;
        CFG_START_LEVEL: start_level_r <= cfg_data;
        CFG_SWITCH_TRIM: switch_trim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured request.
  logic [7:0]  speed_r;
  logic        dir_r, sw_r, stop_r;
  logic [11:0] sample_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      speed_r  <= in_speed;
      dir_r    <= in_direction;
      sw_r     <= in_switching_mode;
      stop_r   <= in_stop_request;
      sample_r <= in_motor_sample & SAMPLE_MASK;
    end
  end

  // Motor state.
  phase_t      phase_r, phase_nxt;
  logic [7:0]  last_speed_r, last_speed_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] ref_sum_r, ref_sum_nxt;
  logic [15:0] cur_sum_r, cur_sum_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  duty_a_r, duty_a_nxt;
  logic [7:0]  duty_b_r, duty_b_nxt;
  logic [7:0]  held_start_r, held_start_nxt;
  logic        upd_r, upd_nxt;

  // Mapping pipeline registers.
  logic [7:0]  range_r;
  logic [15:0] prod_r;

  // Helper values for the decide step.
  logic [15:0] tick_sat;
  logic [15:0] ref_add, cur_add;
  logic [3:0]  cnt_inc;
  logic        win_done;
  logic [19:0] cur_x10, ref_x7;
  logic [7:0]  kick_pwm;
  logic        need_drive;

  assign tick_sat = (tick_r == TICK_MAX) ? tick_r : tick_r + 16'd1;
  assign ref_add  = ref_sum_r + {4'b0, sample_r};
  assign cur_add  = cur_sum_r + {4'b0, sample_r};
  assign cnt_inc  = cnt_r + 4'd1;
  assign win_done = (cnt_inc == WIN_COUNT);
  assign cur_x10  = {1'b0, cur_add, 3'b0} + {3'b0, cur_add, 1'b0};
  assign ref_x7   = {1'b0, ref_sum_r, 3'b0} - {4'b0, ref_sum_r};
  assign kick_pwm = DUTY_OFF - kick_level_r;

  // Duty mapping: maximum level, range, and the scaled product divided by 255.
  logic [15:0] trim_x255;
  logic [7:0]  max_level;
  logic [7:0]  range_c;
  logic [16:0] quot_sum;
  logic [7:0]  quot;
  logic [7:0]  map_pwm;

  assign trim_x255 = {switch_trim_r, 8'b0} - {8'b0, switch_trim_r};
  assign max_level = sw_r ? trim_x255[14:7] : DUTY_OFF;
  assign range_c   = (held_start_r < max_level) ? (max_level - held_start_r) : held_start_r;
  // Exact quotient by 255 for products up to 255 * 255.
  assign quot_sum  = {1'b0, prod_r} + {9'b0, prod_r[15:8]} + 17'd1;
  assign quot      = quot_sum[15:8];
  assign map_pwm   = DUTY_OFF - (held_start_r + quot);

  // Phase transitions for one tick, and the duty write of the mapping step.
  always_comb begin
    phase_nxt      = phase_r;
    last_speed_nxt = last_speed_r;
    tick_nxt       = tick_r;
    ref_sum_nxt    = ref_sum_r;
    cur_sum_nxt    = cur_sum_r;
    cnt_nxt        = cnt_r;
    duty_a_nxt     = duty_a_r;
    duty_b_nxt     = duty_b_r;
    held_start_nxt = held_start_r;
    upd_nxt        = upd_r;
    need_drive     = 1'b0;

    if (stop_r || (speed_r == 8'd0)) begin
      duty_a_nxt     = DUTY_OFF;
      duty_b_nxt     = DUTY_OFF;
      phase_nxt      = PH_STOPPED;
      last_speed_nxt = '0;
      upd_nxt        = 1'b1;
    end else begin
      upd_nxt = 1'b0;
      case (phase_r)
        PH_STOPPED: begin
          last_speed_nxt = speed_r;
          duty_a_nxt     = dir_r ? DUTY_OFF : kick_pwm;
          duty_b_nxt     = dir_r ? kick_pwm : DUTY_OFF;
          tick_nxt       = '0;
          phase_nxt      = PH_STARTING;
          upd_nxt        = 1'b1;
        end
        PH_STARTING: begin
          tick_nxt = tick_sat;
          if (tick_sat >= {8'b0, kick_ticks_r}) begin
            phase_nxt      = PH_MOVING;
            held_start_nxt = start_level_r;
            need_drive     = 1'b1;
            upd_nxt        = 1'b1;
          end
        end
        PH_MOVING: begin
          if (last_speed_r < speed_r) begin
            phase_nxt      = PH_BEFORE;
            ref_sum_nxt    = '0;
            cur_sum_nxt    = '0;
            cnt_nxt        = '0;
            last_speed_nxt = speed_r;
            need_drive     = 1'b1;
            upd_nxt        = 1'b1;
          end
        end
        PH_BEFORE: begin
          ref_sum_nxt = ref_add;
          cnt_nxt     = cnt_inc;
          if (win_done) begin
            cnt_nxt   = '0;
            tick_nxt  = '0;
            phase_nxt = PH_PEAK;
          end
        end
        PH_PEAK: begin
          cur_sum_nxt = cur_add;
          cnt_nxt     = cnt_inc;
          if (win_done) begin
            tick_nxt = tick_sat;
            if (cur_add < ref_sum_r) begin
              tick_nxt  = '0;
              phase_nxt = PH_DROP;
            end else begin
              ref_sum_nxt = cur_add;
            end
            cur_sum_nxt = '0;
            cnt_nxt     = '0;
          end
        end
        PH_DROP: begin
          cur_sum_nxt = cur_add;
          cnt_nxt     = cnt_inc;
          if (win_done) begin
            tick_nxt = tick_sat;
            if ((cur_x10 < ref_x7) || (tick_sat > DROP_MAX_WINDOWS)) begin
              phase_nxt = PH_MOVING;
            end else begin
              cnt_nxt     = '0;
              cur_sum_nxt = '0;
            end
          end
        end
        default: ;
      endcase
    end

    // Outside the decide step only the mapping result may touch the duties.
    if (!cmd.decide) begin
      phase_nxt      = phase_r;
      last_speed_nxt = last_speed_r;
      tick_nxt       = tick_r;
      ref_sum_nxt    = ref_sum_r;
      cur_sum_nxt    = cur_sum_r;
      cnt_nxt        = cnt_r;
      duty_a_nxt     = duty_a_r;
      duty_b_nxt     = duty_b_r;
      held_start_nxt = held_start_r;
      upd_nxt        = upd_r;
      if (cmd.apply) begin
        duty_a_nxt = dir_r ? DUTY_OFF : map_pwm;
        duty_b_nxt = dir_r ? map_pwm : DUTY_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_STOPPED;
      last_speed_r <= '0;
      tick_r       <= '0;
      ref_sum_r    <= '0;
      cur_sum_r    <= '0;
      cnt_r        <= '0;
      duty_a_r     <= DUTY_OFF;
      duty_b_r     <= DUTY_OFF;
      held_start_r <= '0;
      upd_r        <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      last_speed_r <= last_speed_nxt;
      tick_r       <= tick_nxt;
      ref_sum_r    <= ref_sum_nxt;
      cur_sum_r    <= cur_sum_nxt;
      cnt_r        <= cnt_nxt;
      duty_a_r     <= duty_a_nxt;
      duty_b_r     <= duty_b_nxt;
      held_start_r <= held_start_nxt;
      upd_r        <= upd_nxt;
    end
  end

  // Mapping pipeline: range first, then the product with the speed.
  always_ff @(posedge clk) begin
    if (cmd.calc_range) begin
      range_r <= range_c;
    end
    if (cmd.calc_mul) begin
      prod_r <= range_r * speed_r;
    end
  end

  assign sts.need_drive = need_drive;

  // Result register.
  logic [7:0] out_a_r, out_b_r;
  logic       out_upd_r, out_rta_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_a_r   <= duty_a_r;
      out_b_r   <= duty_b_r;
      out_upd_r <= upd_r;
      out_rta_r <= (phase_r == PH_STOPPED) || (phase_r == PH_MOVING);
    end
  end

  assign out_duty_pin_a          = out_a_r;
  assign out_duty_pin_b          = out_b_r;
  assign out_duty_update         = out_upd_r;
  assign out_ready_to_accelerate = out_rta_r;

endmodule

>>> hdl/dc_motor_kickstart_speed_controller_core.sv
// A request passes the decide step and then the done step, where its result is registered;
// when the duty is remapped, range, multiply and divide-by-255 run in between, one registered step
// each in the datapath. A new request waits for the sequencer to return to idle.
// A waiting result sits in its own register, so the next request can start before it is taken.
// Reset is synchronous and active low: phase stopped, both duties off (255), sums and counters
// zero, switch trim 128 and all other configuration registers zero.
module dc_motor_kickstart_speed_controller_core
  import dmks_pkg::*;
#(
  parameter int WINDOW_SAMPLES = 10,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_speed,
  input  logic        in_direction,
  input  logic        in_switching_mode,
  input  logic        in_stop_request,
  input  logic [11:0] in_motor_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_duty_pin_a,
  output logic [7:0]  out_duty_pin_b,
  output logic        out_duty_update,
  output logic        out_ready_to_accelerate
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer.
  dmks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  dmks_datapath #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_datapath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_speed                (in_speed),
    .in_direction            (in_direction),
    .in_switching_mode       (in_switching_mode),
    .in_stop_request         (in_stop_request),
    .in_motor_sample         (in_motor_sample),
    .out_duty_pin_a          (out_duty_pin_a),
    .out_duty_pin_b          (out_duty_pin_b),
    .out_duty_update         (out_duty_update),
    .out_ready_to_accelerate (out_ready_to_accelerate)
  );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the DC motor kick-start speed controller core.
`timescale 1ns / 1ps

module testbench;
  import dmks_pkg::*;

  // One control tick request and one duty result.
  typedef struct packed {
    logic [7:0]  speed;
    logic        direction;
    logic        switching;
    logic        stop;
    logic [11:0] sample;
  } motor_tick_t;

  typedef struct packed {
    logic [7:0] pin_a;
    logic [7:0] pin_b;
    logic       update;
    logic       accel_ready;
  } duty_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_speed;
  logic        in_direction;
  logic        in_switching_mode;
  logic        in_stop_request;
  logic [11:0] in_motor_sample;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_duty_pin_a;
  logic [7:0]  out_duty_pin_b;
  logic        out_duty_update;
  logic        out_ready_to_accelerate;

  dc_motor_kickstart_speed_controller_core dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_speed                (in_speed),
    .in_direction            (in_direction),
    .in_switching_mode       (in_switching_mode),
    .in_stop_request         (in_stop_request),
    .in_motor_sample         (in_motor_sample),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_duty_pin_a          (out_duty_pin_a),
    .out_duty_pin_b          (out_duty_pin_b),
    .out_duty_update         (out_duty_update),
    .out_ready_to_accelerate (out_ready_to_accelerate)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state, a private copy of what the controller holds.
  phase_t      ctl_phase;
  logic [7:0]  held_speed;
  logic [15:0] tick_count;
  logic [15:0] ref_window;
  logic [15:0] cur_window;
  logic [3:0]  window_fill;
  logic [7:0]  pin_a_duty;
  logic [7:0]  pin_b_duty;
  logic [7:0]  captured_floor;
  logic [7:0]  kick_level_cfg;
  logic [7:0]  kick_ticks_cfg;
  logic [7:0]  start_level_cfg;
  logic [7:0]  switch_trim_cfg;

  duty_result_t expected_duties[$];
  int           mismatch_count;
  int           sent_count;
  bit           in_quiet;
  bit           out_quiet;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic logic [7:0] mapped_duty(input logic [7:0] spd, input logic sw,
                                             input logic [7:0] floor_lvl);
    int top;
    int span;
    // The trimmed maximum and the duty both wrap as 8-bit values.
    top = sw ? ((255 * int'(switch_trim_cfg)) / 128) % 256 : 255;
    span = (int'(floor_lvl) < top) ? top - int'(floor_lvl) : int'(floor_lvl);
    return 8'((255 - (int'(floor_lvl) + (span * int'(spd)) / 255)) & 255);
  endfunction

  task automatic drive_pins(input logic [7:0] spd, input logic dir, input logic sw);
    logic [7:0] pwm;
    pwm = mapped_duty(spd, sw, captured_floor);
    pin_a_duty = DUTY_OFF;
    pin_b_duty = DUTY_OFF;
    if (dir) pin_b_duty = pwm;
    else pin_a_duty = pwm;
  endtask

  task automatic bump_ticks();
    if (tick_count != TICK_MAX) tick_count = tick_count + 16'd1;
  endtask

  // Adds a sample to the chosen window sum; true once the window is full.
  function automatic bit window_full(input bit to_reference, input logic [11:0] smp);
    if (to_reference) ref_window = ref_window + {4'd0, smp};
    else cur_window = cur_window + {4'd0, smp};
    window_fill = window_fill + 4'd1;
    return window_fill == 4'(10);
  endfunction

  // Advances the predictor by one accepted tick and queues the expected duties.
  task automatic predict_duties(input motor_tick_t t);
    logic         upd;
    duty_result_t res;
    upd = 1'b0;
    if (t.stop || t.speed == 8'd0) begin
      pin_a_duty = DUTY_OFF;
      pin_b_duty = DUTY_OFF;
      ctl_phase = PH_STOPPED;
      held_speed = 8'd0;
      upd = 1'b1;
    end else begin
      case (ctl_phase)
        PH_STOPPED: begin
          held_speed = t.speed;
          pin_a_duty = DUTY_OFF;
          pin_b_duty = DUTY_OFF;
          if (t.direction) pin_b_duty = DUTY_OFF - kick_level_cfg;
          else pin_a_duty = DUTY_OFF - kick_level_cfg;
          tick_count = 16'd0;
          ctl_phase = PH_STARTING;
          upd = 1'b1;
        end
        PH_STARTING: begin
          bump_ticks();
          if (tick_count >= {8'd0, kick_ticks_cfg}) begin
            ctl_phase = PH_MOVING;
            captured_floor = start_level_cfg;
            drive_pins(t.speed, t.direction, t.switching);
            upd = 1'b1;
          end
        end
        PH_MOVING: begin
          // Only a speed increase is acted on; it opens the acceleration watch.
          if (held_speed < t.speed) begin
            ctl_phase = PH_BEFORE;
            ref_window = 16'd0;
            cur_window = 16'd0;
            window_fill = 4'd0;
            held_speed = t.speed;
            drive_pins(t.speed, t.direction, t.switching);
            upd = 1'b1;
          end
        end
        PH_BEFORE: begin
          if (window_full(1'b1, t.sample)) begin
            window_fill = 4'd0;
            tick_count = 16'd0;
            ctl_phase = PH_PEAK;
          end
        end
        PH_PEAK: begin
          if (window_full(1'b0, t.sample)) begin
            bump_ticks();
            if (cur_window < ref_window) begin
              tick_count = 16'd0;
              ctl_phase = PH_DROP;
            end else begin
              ref_window = cur_window;
            end
            cur_window = 16'd0;
            window_fill = 4'd0;
          end
        end
        PH_DROP: begin
          if (window_full(1'b0, t.sample)) begin
            bump_ticks();
            if (int'(cur_window) * 10 < int'(ref_window) * 7 ||
                tick_count > DROP_MAX_WINDOWS) begin
              ctl_phase = PH_MOVING;
            end else begin
              window_fill = 4'd0;
              cur_window = 16'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.pin_a = pin_a_duty;
    res.pin_b = pin_b_duty;
    res.update = upd;
    res.accel_ready = (ctl_phase == PH_STOPPED || ctl_phase == PH_MOVING);
    expected_duties.push_back(res);
  endtask

  // Sends one tick request; returns at the falling edge after it was taken.
  task automatic send_tick(input logic [7:0] spd, input logic dir, input logic sw,
                           input logic stp, input logic [11:0] smp);
    int          gap;
    motor_tick_t t;
    gap = in_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    t = '{speed: spd, direction: dir, switching: sw, stop: stp, sample: smp};
    in_speed <= spd;
    in_direction <= dir;
    in_switching_mode <= sw;
    in_stop_request <= stp;
    in_motor_sample <= smp;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_duties(t);
    sent_count++;
    @(negedge clk);
  endtask

  // Lets all outstanding results drain, then gives the sequencer time to return to idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_duties.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] kl, input logic [7:0] kt,
                                input logic [7:0] sl, input logic [7:0] tr);
    logic [7:0] vals[4];
    wait_idle();
    vals = '{kl, kt, sl, tr};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    kick_level_cfg = kl;
    kick_ticks_cfg = kt;
    start_level_cfg = sl;
    switch_trim_cfg = tr;
  endtask

  // A well-formed run: start, kick, speed up, then a shaped voltage profile.
  task automatic run_session();
    int         spd;
    int         lvl;
    int         shape;
    int         run_len;
    int         hold;
    int         r;
    int         smp;
    logic       dir;
    logic       sw;
    dir = 1'($urandom_range(0, 1));
    sw = 1'($urandom_range(0, 1));
    spd = $urandom_range(1, 200);
    in_quiet = ($urandom_range(0, 4) == 0);
    out_quiet = ($urandom_range(0, 4) == 0);
    hold = int'(kick_ticks_cfg) + $urandom_range(1, 3);
    for (int i = 0; i < hold; i++) begin
      send_tick(8'(spd), dir, sw, 1'b0, 12'($urandom_range(0, 4095)));
    end
    if (spd < 255) spd = spd + $urandom_range(1, 255 - spd);
    run_len = $urandom_range(15, 140);
    shape = $urandom_range(0, 3);
    lvl = $urandom_range(1500, 3000);
    for (int i = 0; i < run_len; i++) begin
      // Shapes 1 and 2 rise then fall to find the peak and the drop; shape 0 is random, shape 3 flat.
      case (shape)
        0: lvl = $urandom_range(0, 4095);
        1: lvl = (i < 12) ? lvl + $urandom_range(0, 150) : lvl - $urandom_range(0, 200);
        2: lvl = (i < 12) ? lvl + $urandom_range(0, 100) : lvl - $urandom_range(0, 25);
        default: lvl = lvl;
      endcase
      if (lvl > 4095) lvl = 4095;
      if (lvl < 0) lvl = 0;
      smp = (shape == 0) ? lvl : lvl + $urandom_range(0, 40);
      if (smp > 4095) smp = 4095;
      r = $urandom_range(0, 99);
      if (r < 3 && spd < 255) begin
        spd = spd + $urandom_range(1, 255 - spd);
        send_tick(8'(spd), dir, sw, 1'b0, 12'(smp));
      end else if (r < 6 && spd > 1) begin
        // A lower speed for one tick is held off until the next stop.
        send_tick(8'($urandom_range(1, spd - 1)), dir, sw, 1'b0, 12'(smp));
      end else begin
        send_tick(8'(spd), dir, sw, r == 99, 12'(smp));
      end
    end
    if ($urandom_range(0, 1)) begin
      send_tick(8'd0, dir, sw, 1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
    end else begin
      send_tick(8'($urandom_range(1, 255)), dir, sw, 1'b1, 12'($urandom_range(0, 4095)));
    end
  endtask

  // Unstructured ticks with frequent stops and zero speeds.
  task automatic run_noise(input int count);
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_tick(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 9) == 0, 12'($urandom_range(0, 4095)));
    end
  endtask

  task automatic test_directed_cases();
    // Reset configuration: no kick, zero start level, unity trim.
    send_tick(8'd0, 1'b0, 1'b0, 1'b0, 12'd0);
    send_tick(8'd255, 1'b0, 1'b0, 1'b0, 12'hFFF);
    send_tick(8'd255, 1'b0, 1'b0, 1'b0, 12'd0);
    send_tick(8'd255, 1'b1, 1'b1, 1'b1, 12'd0);
    // Kick on pin b, full trim, speed up into the acceleration watch.
    apply_settings(8'd180, 8'd1, 8'd50, 8'd255);
    send_tick(8'd1, 1'b1, 1'b1, 1'b0, 12'hAAA);
    send_tick(8'd1, 1'b1, 1'b1, 1'b0, 12'h555);
    send_tick(8'd200, 1'b1, 1'b1, 1'b0, 12'hFFF);
    send_tick(8'd100, 1'b1, 1'b1, 1'b0, 12'hFFF);
    send_tick(8'd200, 1'b1, 1'b1, 1'b0, 12'd0);
    send_tick(8'd200, 1'b1, 1'b1, 1'b0, 12'hFFF);
    send_tick(8'd200, 1'b0, 1'b0, 1'b0, 12'd0);
    send_tick(8'd0, 1'b1, 1'b1, 1'b0, 12'hFFF);
    send_tick(8'd0, 1'b0, 1'b0, 1'b1, 12'd0);
    // Start level at or above a zero maximum: the span falls back to the level.
    apply_settings(8'd255, 8'd0, 8'd255, 8'd0);
    send_tick(8'd128, 1'b0, 1'b1, 1'b0, 12'd1);
    send_tick(8'd128, 1'b0, 1'b1, 1'b0, 12'd2);
    send_tick(8'd255, 1'b0, 1'b0, 1'b0, 12'd4);
    send_tick(8'd254, 1'b0, 1'b0, 1'b0, 12'd8);
    send_tick(8'd1, 1'b1, 1'b0, 1'b1, 12'h800);
  endtask

  task automatic test_settings_sweep();
    logic [7:0] kl[8] = '{8'd0, 8'd255, 8'd100, 8'd0, 8'd200, 8'd37, 8'd0, 8'd0};
    logic [7:0] kt[8] = '{8'd0, 8'd3, 8'd0, 8'd255, 8'd5, 8'd2, 8'd0, 8'd0};
    logic [7:0] sl[8] = '{8'd0, 8'd40, 8'd0, 8'd255, 8'd255, 8'd90, 8'd0, 8'd0};
    logic [7:0] tr[8] = '{8'd128, 8'd128, 8'd255, 8'd0, 8'd64, 8'd200, 8'd0, 8'd0};
    int         budget;
    int         stop_at;
    for (int p = 0; p < 8; p++) begin
      if (p >= 6) begin
        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 8)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        apply_settings(kl[p], kt[p], sl[p], tr[p]);
      end
      // Each phase overshoots its budget by about one session.
      budget = (kt[p] == 8'd255) ? 250 : ((p >= 6) ? 100 : 150);
      stop_at = sent_count + budget;
      while (sent_count < stop_at) begin
        if ($urandom_range(0, 4) == 0) run_noise($urandom_range(10, 30));
        else run_session();
      end
    end
  endtask

  // Result side: random back-pressure and a field-by-field check.
  initial begin
    int           stall;
    duty_result_t exp_res;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_duties.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        exp_res = expected_duties.pop_front();
        if (out_duty_pin_a !== exp_res.pin_a) begin
          report_mismatch($sformatf("duty_pin_a %0d, expected %0d",
                                    out_duty_pin_a, exp_res.pin_a));
        end
        if (out_duty_pin_b !== exp_res.pin_b) begin
          report_mismatch($sformatf("duty_pin_b %0d, expected %0d",
                                    out_duty_pin_b, exp_res.pin_b));
        end
        if (out_duty_update !== exp_res.update) begin
          report_mismatch($sformatf("duty_update %b, expected %b",
                                    out_duty_update, exp_res.update));
        end
        if (out_ready_to_accelerate !== exp_res.accel_ready) begin
          report_mismatch($sformatf("ready_to_accelerate %b, expected %b",
                                    out_ready_to_accelerate, exp_res.accel_ready));
        end
      end
      @(negedge clk);
    end
  end

  // Stimulus sequence.
  initial begin
    int waited;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_KICK_LEVEL;
    cfg_data = 8'd0;
    in_valid = 1'b0;
    in_speed = 8'd0;
    in_direction = 1'b0;
    in_switching_mode = 1'b0;
    in_stop_request = 1'b0;
    in_motor_sample = 12'd0;
    mismatch_count = 0;
    sent_count = 0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    ctl_phase = PH_STOPPED;
    held_speed = 8'd0;
    tick_count = 16'd0;
    ref_window = 16'd0;
    cur_window = 16'd0;
    window_fill = 4'd0;
    pin_a_duty = DUTY_OFF;
    pin_b_duty = DUTY_OFF;
    captured_floor = 8'd0;
    kick_level_cfg = 8'd0;
    kick_ticks_cfg = 8'd0;
    start_level_cfg = 8'd0;
    switch_trim_cfg = TRIM_RESET;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_settings_sweep();

    // Drain with a bound, then allow for the longest remap latency.
    in_valid <= 1'b0;
    waited = 0;
    while (expected_duties.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_duties.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_duties.size()));
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
